### sv/sla_pkg.sv
// Shared types, codes and constant tables for the serial line assembler.
`timescale 1ns / 1ps

package sla_pkg;

    // Input beat payload
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [4:0] read_index;
    } in_item_t;

    // Output beat payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last;
        logic       line_ready;
        logic [5:0] line_length;
    } out_item_t;

    // Item modes
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    // Overflow message length and per-item result cap
    localparam int MSG_LEN     = 40;
    localparam int MAX_RESULTS = 40;

    // Characters that go into the line
    function automatic logic is_storable(input logic [7:0] c);
        logic ok;
        ok = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
             ((c >= "A") && (c <= "Z")) || (c == "-") || (c == CH_SP) ||
             (c == ".") || (c == ":") || (c == "?") || (c == "_");
        return ok;
    endfunction

    // Overflow message, CR LF included
    function automatic logic [7:0] msg_byte(input logic [5:0] i);
        logic [7:0] b;
        case (i)
            6'd0:  b = "R";
            6'd1:  b = "e";
            6'd2:  b = "c";
            6'd3:  b = "e";
            6'd4:  b = "i";
            6'd5:  b = "v";
            6'd6:  b = "e";
            6'd7:  b = "d";
            6'd8:  b = CH_SP;
            6'd9:  b = "c";
            6'd10: b = "h";
            6'd11: b = "a";
            6'd12: b = "r";
            6'd13: b = "a";
            6'd14: b = "c";
            6'd15: b = "t";
            6'd16: b = "e";
            6'd17: b = "r";
            6'd18: b = "s";
            6'd19: b = CH_SP;
            6'd20: b = "e";
            6'd21: b = "x";
            6'd22: b = "c";
            6'd23: b = "e";
            6'd24: b = "e";
            6'd25: b = "d";
            6'd26: b = CH_SP;
            6'd27: b = "m";
            6'd28: b = "a";
            6'd29: b = "x";
            6'd30: b = CH_SP;
            6'd31: b = "n";
            6'd32: b = "u";
            6'd33: b = "m";
            6'd34: b = "b";
            6'd35: b = "e";
            6'd36: b = "r";
            6'd37: b = ".";
            6'd38: b = CH_CR;
            6'd39: b = CH_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/serial_line_assembler_with_echo_unit.sv
// Results leave via the output register; a line echo reads the line store first. A status
// item gives one beat, a backspace BS SP BS, an overflow the message table one byte per
// cycle unless the output stalls, a line echo each stored character (read, then emitted)
// and then CR LF. Items are taken one at a time, up to 40 results each.
// Reset clears the character count, the line-complete flag and the sequencer; the line
// store is not cleared and holds no valid data until written.
`timescale 1ns / 1ps

module serial_line_assembler_with_echo_unit
    import sla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW = $clog2(LINE_CAPACITY);

    logic          em_valid;
    logic          em_ready;
    out_item_t     em_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Sequencer
    sla_seq #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .AW            (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .em_valid (em_valid),
        .em_ready (em_ready),
        .em_data  (em_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Line store
    sla_line_mem #(
        .DEPTH (LINE_CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register
    sla_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .em_valid  (em_valid),
        .em_ready  (em_ready),
        .em_data   (em_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sv/sla_line_mem.sv
// Line store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sla_line_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write stored character
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sla_out_reg.sv
// Output register that parts the sequencer from the result channel.
`timescale 1ns / 1ps

module sla_out_reg
    import sla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      em_valid,
    output logic      em_ready,
    input  out_item_t em_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign em_ready = !valid_reg || out_ready;

    // Advance when the slot is free or drains this cycle
    always_comb
    begin
        valid_next = valid_reg;
        if (em_ready)
        begin
            valid_next = em_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load beat
    always_ff @(posedge clk)
    begin
        if (em_ready && em_valid)
        begin
            data_reg <= em_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/sla_seq.sv
// Line state and echo sequencer: handles one item, drives the line store.
`timescale 1ns / 1ps

module sla_seq
    import sla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32,
    parameter int AW            = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_data,
    output logic          em_valid,
    input  logic          em_ready,
    output out_item_t     em_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data
);

    localparam int PW = (AW > 6) ? AW : 6;
    localparam logic [AW:0] CAP_V  = (AW + 1)'(LINE_CAPACITY);
    localparam logic [7:0]  CAP_8  = 8'(LINE_CAPACITY);
    localparam logic [5:0]  RES_LAST = 6'(MAX_RESULTS - 1);
    localparam logic [5:0]  MSG_LAST = 6'(MSG_LEN - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LINE_RD = 4'd1;
    localparam logic [3:0] S_LINE_EM = 4'd2;
    localparam logic [3:0] S_CR      = 4'd3;
    localparam logic [3:0] S_LF      = 4'd4;
    localparam logic [3:0] S_BS      = 4'd5;
    localparam logic [3:0] S_MSG     = 4'd6;
    localparam logic [3:0] S_STAT    = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [5:0]    res_reg, res_next;
    logic [AW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic          zero_reg, zero_next;

    logic [AW:0]   cnt_inc;
    logic [PW-1:0] pos_inc;
    logic [31:0]   idx_ext;
    logic          nat_last;
    logic          fire;

    assign cnt_inc  = {1'b0, count_reg} + 1'b1;
    assign pos_inc  = pos_reg + 1'b1;
    assign idx_ext  = 32'(in_data.read_index);
    assign in_ready = (state_reg == S_IDLE);
    assign fire     = em_valid && em_ready;

    // Build the beat for the current step
    always_comb
    begin
        em_valid = 1'b0;
        em_data.out_byte = 8'h00;
        em_data.out_kind = KIND_ECHO;
        nat_last = 1'b0;
        unique case (state_reg) inside
            S_IDLE, S_LINE_RD:
            begin
                em_valid = 1'b0;
            end
            S_LINE_EM:
            begin
                em_valid = 1'b1;
                em_data.out_byte = rd_data;
            end
            S_CR:
            begin
                em_valid = 1'b1;
                em_data.out_byte = CH_CR;
            end
            S_LF:
            begin
                em_valid = 1'b1;
                em_data.out_byte = CH_LF;
                nat_last = 1'b1;
            end
            S_BS:
            begin
                em_valid = 1'b1;
                em_data.out_byte = (pos_reg == PW'(1)) ? CH_SP : CH_BS;
                nat_last = (pos_reg == PW'(2));
            end
            S_MSG:
            begin
                em_valid = 1'b1;
                em_data.out_byte = msg_byte(pos_reg[5:0]);
                nat_last = (pos_reg[5:0] == MSG_LAST);
            end
            S_STAT:
            begin
                em_valid = 1'b1;
                em_data.out_kind = KIND_STATUS;
                nat_last = 1'b1;
            end
            S_READ:
            begin
                em_valid = 1'b1;
                em_data.out_byte = zero_reg ? 8'h00 : rd_data;
                em_data.out_kind = KIND_READ;
                nat_last = 1'b1;
            end
            default:
            begin
                em_valid = 1'b0;
            end
        endcase
        em_data.last        = nat_last || (res_reg == RES_LAST);
        em_data.line_ready  = done_reg;
        em_data.line_length = 6'(count_reg);
    end

    // Next state, line state update and store access
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        count_next = count_reg;
        done_next  = done_reg;
        zero_next  = zero_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg;
        wr_data    = in_data.rx_byte;
        rd_en      = 1'b0;
        rd_addr    = pos_reg[AW-1:0];

        if (state_reg == S_IDLE)
        begin
            if (in_valid)
            begin
                res_next   = 6'd0;
                pos_next   = '0;
                state_next = S_STAT;
                case (in_data.mode)
                    MODE_BYTE:
                    begin
                        if (!done_reg)
                        begin
                            if (in_data.rx_byte == CH_BS)
                            begin
                                state_next = S_BS;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            else if (in_data.rx_byte == CH_CR)
                            begin
                                done_next  = 1'b1;
                                state_next = (count_reg == '0) ? S_CR : S_LINE_RD;
                            end
                            else if (is_storable(in_data.rx_byte))
                            begin
                                wr_en = 1'b1;
                                if (cnt_inc == CAP_V)
                                begin
                                    count_next = '0;
                                    state_next = S_MSG;
                                end
                                else
                                begin
                                    count_next = cnt_inc[AW-1:0];
                                end
                            end
                        end
                    end
                    MODE_RELEASE:
                    begin
                        count_next = '0;
                        done_next  = 1'b0;
                    end
                    MODE_READ:
                    begin
                        state_next = S_READ;
                        zero_next  = !({3'b000, in_data.read_index} < CAP_8);
                        rd_en      = 1'b1;
                        rd_addr    = idx_ext[AW-1:0];
                    end
                    default:
                    begin
                        state_next = S_STAT;
                    end
                endcase
            end
        end
        else if (state_reg == S_LINE_RD)
        begin
            // Fetch next stored character
            rd_en      = 1'b1;
            state_next = S_LINE_EM;
        end
        else if (fire)
        begin
            res_next = res_reg + 1'b1;
            pos_next = pos_inc;
            if (em_data.last)
            begin
                state_next = S_IDLE;
            end
            else if (state_reg == S_LINE_EM)
            begin
                state_next = (pos_inc == PW'(count_reg)) ? S_CR : S_LINE_RD;
            end
            else if (state_reg == S_CR)
            begin
                state_next = S_LF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Step counters and read flag
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        zero_reg <= zero_next;
    end

endmodule
